>>> rtl/skwn_pkg.sv
// ----------------------------------------------------------------------------
// skwn_pkg - shared types and constants of the skin weight normaliser
// widths, the vertex snapshot passed from front to back, helper sizes
// ----------------------------------------------------------------------------
package skwn_pkg;

  localparam int BONE_BITS        = 16;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int IN_W             = 16;
  localparam int KEEP_SLOTS       = 4;
  localparam int SLOT_W           = $clog2(KEEP_SLOTS);
  localparam int CNT_W            = $clog2(KEEP_SLOTS + 1);
  localparam int SUM_W            = IN_W + SLOT_W;
  localparam int REM_W            = SUM_W + 1;
  localparam int QW               = WEIGHT_FRAC_BITS + 1;
  localparam int STEP_W           = $clog2(WEIGHT_FRAC_BITS + 1);
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IN_W-1:0]      wgt_t;
  typedef logic [BONE_BITS-1:0] bone_t;
  typedef logic [QW-1:0]        nwgt_t;

  // kept list of one vertex, sorted largest first
  typedef struct packed {
    wgt_t  [KEEP_SLOTS-1:0] w;
    bone_t [KEEP_SLOTS-1:0] b;
    logic  [CNT_W-1:0]      n;
  } snap_t;

  // queue side status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> rtl/skin_weight_top4_normalizer_core.sv
// ----------------------------------------------------------------------------
// skin_weight_top4_normalizer_core - top-four bone weight normaliser
// streams influences in, gives one normalised top-four set per vertex
// ----------------------------------------------------------------------------
// Influences of a vertex are pushed one per transaction; each is taken by
// the front, which keeps a sorted list of the four largest nonzero weights
// (equal weights keep arrival order). The transaction with in_is_last set
// closes the vertex: its list goes into a two-entry queue and the front
// starts the next vertex in the next cycle. The back pops a list, adds the
// kept weights and runs four restoring divider lanes in parallel, one
// quotient bit per cycle; the slower of the intake and the divider loop sets
// the sustained rate. Weights come out as floor(w * 2^16 / sum), largest
// first; unused slots read weight zero with bone_0, and ok is low when no
// weight was kept. A finished result waits in the output register, and the
// back may finish the next vertex meanwhile; in_full rises only when both
// queue entries are taken.
module skin_weight_top4_normalizer_core (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic [skwn_pkg::IN_W-1:0] in_bone,
  input  logic [skwn_pkg::IN_W-1:0] in_weight,
  input  logic in_is_last,
  output logic out_empty,
  input  logic out_pop,
  output logic out_ok,
  output logic [skwn_pkg::QW-1:0]   out_weight_0,
  output logic [skwn_pkg::QW-1:0]   out_weight_1,
  output logic [skwn_pkg::QW-1:0]   out_weight_2,
  output logic [skwn_pkg::QW-1:0]   out_weight_3,
  output logic [skwn_pkg::IN_W-1:0] out_bone_0,
  output logic [skwn_pkg::IN_W-1:0] out_bone_1,
  output logic [skwn_pkg::IN_W-1:0] out_bone_2,
  output logic [skwn_pkg::IN_W-1:0] out_bone_3
);
  import skwn_pkg::*;

  // front to queue
  logic   snap_push;
  snap_t  snap_in;
  // queue to back
  logic   snap_pop;
  snap_t  snap_out;
  qstat_t qstat;

  skwn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_bone    (in_bone),
    .in_weight  (in_weight),
    .in_is_last (in_is_last),
    .qstat      (qstat),
    .snap_push  (snap_push),
    .snap       (snap_in)
  );

  // decouples intake from the divider so both can stall on their own
  skwn_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (snap_push),
    .wr_data (snap_in),
    .rd      (snap_pop),
    .rd_data (snap_out),
    .qstat   (qstat)
  );

  skwn_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .qstat        (qstat),
    .q_rd         (snap_pop),
    .q_data       (snap_out),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_ok       (out_ok),
    .out_weight_0 (out_weight_0),
    .out_weight_1 (out_weight_1),
    .out_weight_2 (out_weight_2),
    .out_weight_3 (out_weight_3),
    .out_bone_0   (out_bone_0),
    .out_bone_1   (out_bone_1),
    .out_bone_2   (out_bone_2),
    .out_bone_3   (out_bone_3)
  );

endmodule

>>> rtl/skwn_front.sv
// ----------------------------------------------------------------------------
// skwn_front - influence intake and top-four insertion
// keeps the sorted list of the four largest weights, hands it on at last
// ----------------------------------------------------------------------------
module skwn_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [skwn_pkg::IN_W-1:0] in_bone,
  input  logic [skwn_pkg::IN_W-1:0] in_weight,
  input  logic                 in_is_last,
  input  skwn_pkg::qstat_t     qstat,
  output logic                 snap_push,
  output skwn_pkg::snap_t      snap
);
  import skwn_pkg::*;

  wgt_t  [KEEP_SLOTS-1:0] kw_r, kw_nxt;
  bone_t [KEEP_SLOTS-1:0] kb_r, kb_nxt;
  logic  [CNT_W-1:0]      n_r, n_nxt;
  logic  [CNT_W-1:0]      pos;
  logic                   ins;
  logic                   accept;
  bone_t                  bone_in;

  assign in_full = qstat.full;
  assign accept  = in_push && !in_full;
  assign bone_in = in_bone[BONE_BITS-1:0];

  always_comb begin
    pos = '0;
    for (int i = 0; i < KEEP_SLOTS; i++) begin
      // list is sorted, so the entries not below the new weight form a prefix
      if ((CNT_W'(i) < n_r) && (kw_r[i] >= in_weight)) begin
        pos = pos + CNT_W'(1);
      end
    end
    ins    = (in_weight != '0) && (pos < CNT_W'(KEEP_SLOTS));
    kw_nxt = kw_r;
    kb_nxt = kb_r;
    n_nxt  = n_r;
    if (ins) begin
      for (int i = 1; i < KEEP_SLOTS; i++) begin
        if (CNT_W'(i) > pos) begin
          kw_nxt[i] = kw_r[i-1];
          kb_nxt[i] = kb_r[i-1];
        end
      end
      kw_nxt[pos[SLOT_W-1:0]] = in_weight;
      kb_nxt[pos[SLOT_W-1:0]] = bone_in;
      if (n_r < CNT_W'(KEEP_SLOTS)) begin
        n_nxt = n_r + CNT_W'(1);
      end
    end
  end

  assign snap_push = accept && in_is_last;
  assign snap.w    = kw_nxt;
  assign snap.b    = kb_nxt;
  assign snap.n    = n_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_r <= '0;
      kb_r <= '0;
      n_r  <= '0;
    end else if (accept) begin
      if (in_is_last) begin
        kw_r <= '0;
        kb_r <= '0;
        n_r  <= '0;
      end else begin
        kw_r <= kw_nxt;
        kb_r <= kb_nxt;
        n_r  <= n_nxt;
      end
    end
  end

endmodule

>>> rtl/skwn_queue.sv
// ----------------------------------------------------------------------------
// skwn_queue - short snapshot queue between front and back
// two entries in flops, first in first out
// ----------------------------------------------------------------------------
module skwn_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  skwn_pkg::snap_t  wr_data,
  input  logic             rd,
  output skwn_pkg::snap_t  rd_data,
  output skwn_pkg::qstat_t qstat
);
  import skwn_pkg::*;

  snap_t [QUEUE_DEPTH-1:0] mem_r;
  logic  [QPTR_W-1:0]      wp_r, rp_r;
  logic  [QCNT_W-1:0]      cnt_r;
  logic                    do_wr, do_rd;

  assign qstat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_wr       = wr && !qstat.full;
  assign do_rd       = rd && !qstat.empty;
  assign rd_data     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/skwn_back.sv
// ----------------------------------------------------------------------------
// skwn_back - sum and normalise one vertex
// four restoring divider lanes, one quotient bit per cycle, result register
// ----------------------------------------------------------------------------
module skwn_back (
  input  logic             clk,
  input  logic             rst_n,
  input  skwn_pkg::qstat_t qstat,
  output logic             q_rd,
  input  skwn_pkg::snap_t  q_data,
  output logic             out_empty,
  input  logic             out_pop,
  output logic             out_ok,
  output logic [skwn_pkg::QW-1:0]   out_weight_0,
  output logic [skwn_pkg::QW-1:0]   out_weight_1,
  output logic [skwn_pkg::QW-1:0]   out_weight_2,
  output logic [skwn_pkg::QW-1:0]   out_weight_3,
  output logic [skwn_pkg::IN_W-1:0] out_bone_0,
  output logic [skwn_pkg::IN_W-1:0] out_bone_1,
  output logic [skwn_pkg::IN_W-1:0] out_bone_2,
  output logic [skwn_pkg::IN_W-1:0] out_bone_3
);
  import skwn_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                     st_r, st_nxt;
  snap_t                          sn_r;
  logic [SUM_W-1:0]               sum_r, sum_nxt;
  logic [KEEP_SLOTS-1:0][REM_W-1:0] rem_r, rem_nxt;
  nwgt_t [KEEP_SLOTS-1:0]         q_r, q_nxt;
  logic [STEP_W-1:0]              step_r;
  logic                           ov_r;
  logic                           ok_r;
  nwgt_t [KEEP_SLOTS-1:0]         ow_r;
  logic [KEEP_SLOTS-1:0][IN_W-1:0] ob_r;
  logic                           load_out;
  logic                           ge;
  logic [REM_W-1:0]               diff;

  assign q_rd     = (st_r == ST_IDLE) && !qstat.empty;
  assign load_out = (st_r == ST_DONE) && (!ov_r || out_pop);

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < KEEP_SLOTS; i++) begin
      sum_nxt = sum_nxt + SUM_W'(sn_r.w[i]);
    end
  end

  // one restoring step per lane
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    ge      = 1'b0;
    diff    = '0;
    for (int i = 0; i < KEEP_SLOTS; i++) begin
      ge         = rem_r[i] >= REM_W'(sum_r);
      diff       = ge ? (rem_r[i] - REM_W'(sum_r)) : rem_r[i];
      rem_nxt[i] = {diff[REM_W-2:0], 1'b0};
      q_nxt[i]   = {q_r[i][QW-2:0], ge};
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (!qstat.empty) st_nxt = ST_SUM;
      ST_SUM:  st_nxt = ST_DIV;
      ST_DIV:  if (step_r == STEP_W'(WEIGHT_FRAC_BITS)) st_nxt = ST_DONE;
      ST_DONE: if (load_out) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      sn_r <= q_data;
    end
    if (st_r == ST_SUM) begin
      sum_r  <= sum_nxt;
      step_r <= '0;
      q_r    <= '0;
      for (int i = 0; i < KEEP_SLOTS; i++) begin
        rem_r[i] <= REM_W'(sn_r.w[i]);
      end
    end else if (st_r == ST_DIV) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      step_r <= step_r + STEP_W'(1);
    end
    if (load_out) begin
      ok_r <= (sn_r.n != '0);
      for (int i = 0; i < KEEP_SLOTS; i++) begin
        if ((sn_r.n != '0) && (CNT_W'(i) < sn_r.n)) begin
          ow_r[i] <= q_r[i];
          ob_r[i] <= IN_W'(sn_r.b[i]);
        end else begin
          ow_r[i] <= '0;
          ob_r[i] <= IN_W'(sn_r.b[0]);
        end
      end
    end
  end

  assign out_empty    = !ov_r;
  assign out_ok       = ok_r;
  assign out_weight_0 = ow_r[0];
  assign out_weight_1 = ow_r[1];
  assign out_weight_2 = ow_r[2];
  assign out_weight_3 = ow_r[3];
  assign out_bone_0   = ob_r[0];
  assign out_bone_1   = ob_r[1];
  assign out_bone_2   = ob_r[2];
  assign out_bone_3   = ob_r[3];

endmodule

>>> rtl/skwn_checker.sv
// ----------------------------------------------------------------------------
// skwn_checker - port level checks of the normaliser
// result ordering, empty results, hold while stalled, reset state
// ----------------------------------------------------------------------------
module skwn_checker (
  input logic clk,
  input logic rst_n,
  input logic out_empty,
  input logic out_pop,
  input logic out_ok,
  input logic [skwn_pkg::QW-1:0]   out_weight_0,
  input logic [skwn_pkg::QW-1:0]   out_weight_1,
  input logic [skwn_pkg::QW-1:0]   out_weight_2,
  input logic [skwn_pkg::QW-1:0]   out_weight_3,
  input logic [skwn_pkg::IN_W-1:0] out_bone_0,
  input logic [skwn_pkg::IN_W-1:0] out_bone_1,
  input logic [skwn_pkg::IN_W-1:0] out_bone_2,
  input logic [skwn_pkg::IN_W-1:0] out_bone_3
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_ok) && $stable(out_weight_0) &&
       $stable(out_weight_3) && $stable(out_bone_0) && $stable(out_bone_3)))
    else $error("waiting result changed before pop");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_ok) |->
      (out_weight_0 != '0 && out_weight_0 >= out_weight_1 &&
       out_weight_1 >= out_weight_2 && out_weight_2 >= out_weight_3))
    else $error("normalised weights not in descending order");

  a_empty_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_ok) |->
      (out_weight_0 == '0 && out_weight_1 == '0 && out_weight_2 == '0 &&
       out_weight_3 == '0 && out_bone_0 == '0 && out_bone_1 == '0 &&
       out_bone_2 == '0 && out_bone_3 == '0))
    else $error("result without weights is not all zero");

endmodule

bind skin_weight_top4_normalizer_core skwn_checker u_skwn_checker (.*);
